@@ hdl/xrs_pkg.sv @@
// Shared types, constants and generator functions for the xoroshiro128++ random source.
package xrs_pkg;

	localparam int unsigned WORD_W  = 64;
	localparam int unsigned CMD_W   = 3;
	localparam int unsigned BOUND_W = 31;
	localparam int unsigned BITS_W  = 7;
	localparam int unsigned STEP_W  = 32;
	localparam int unsigned CFG_IDX_W = 1;
	localparam int unsigned DIV_CNT_W = 5;

	localparam logic [WORD_W-1:0] ZERO_SEED_LOW  = 64'h9E37_79B9_7F4A_7C15;
	localparam logic [WORD_W-1:0] ZERO_SEED_HIGH = 64'h6A09_E667_F3BC_C909;

	typedef enum logic [CMD_W-1:0] {
		CMD_RESEED  = 3'd0,
		CMD_RAW     = 3'd1,
		CMD_BOUNDED = 3'd2,
		CMD_TOP     = 3'd3,
		CMD_SKIP    = 3'd4
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SEED_HIGH = 1'b0,
		REG_SEED_LOW  = 1'b1
	} reg_idx_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load_item;
		logic reseed;
		logic draw;
		logic skip_step;
		logic mul;
		logic div_start;
		logic div_step;
		logic out_load;
	} dp_ctrl_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		cmd_t cmd;
		logic bound_zero;
		logic count_le1;
		logic low_ge_bound;
		logic thr_done;
		logic low_lt_thr;
		logic div_last;
		logic out_free;
	} dp_stat_t;

	function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] x, input int unsigned r);
		rotl = (x << r) | (x >> (WORD_W - r));
	endfunction

	// Output word of one draw, taken from the current state.
	function automatic logic [WORD_W-1:0] draw_out(input logic [WORD_W-1:0] lo,
		input logic [WORD_W-1:0] hi);
		draw_out = rotl(lo + hi, 17) + lo;
	endfunction

	function automatic logic [WORD_W-1:0] next_lo(input logic [WORD_W-1:0] lo,
		input logic [WORD_W-1:0] hi);
		logic [WORD_W-1:0] s1;
		s1 = hi ^ lo;
		next_lo = rotl(lo, 49) ^ s1 ^ (s1 << 21);
	endfunction

	function automatic logic [WORD_W-1:0] next_hi(input logic [WORD_W-1:0] lo,
		input logic [WORD_W-1:0] hi);
		next_hi = rotl(hi ^ lo, 28);
	endfunction

endpackage

@@ hdl/xrs_if.sv @@
// Handshake interfaces for the command channel and the result channel.
interface xrs_cmd_if;
	logic                             valid;
	logic                             ready;
	logic [xrs_pkg::CMD_W-1:0]        command;
	logic [xrs_pkg::BOUND_W-1:0]      bound;
	logic [xrs_pkg::BITS_W-1:0]       bit_count;
	logic [xrs_pkg::STEP_W-1:0]       step_count;

	modport source (output valid, command, bound, bit_count, step_count, input ready);
	modport sink   (input valid, command, bound, bit_count, step_count, output ready);
endinterface

interface xrs_res_if;
	logic                        valid;
	logic                        ready;
	logic [xrs_pkg::WORD_W-1:0]  value;
	logic                        error;

	modport source (output valid, value, error, input ready);
	modport sink   (input valid, value, error, output ready);
endinterface

@@ hdl/xrs_ctrl.sv @@
// Controller state machine that sequences each command through the datapath.
module xrs_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  xrs_pkg::dp_stat_t stat,
	output xrs_pkg::dp_ctrl_t ctrl
);

	typedef enum logic [7:0] {
		ST_IDLE   = 8'b0000_0001,
		ST_DECODE = 8'b0000_0010,
		ST_SKIP   = 8'b0000_0100,
		ST_DRAW   = 8'b0000_1000,
		ST_MUL    = 8'b0001_0000,
		ST_CHECK  = 8'b0010_0000,
		ST_DIV    = 8'b0100_0000,
		ST_FINISH = 8'b1000_0000
	} state_t;

	state_t state_q;
	state_t state_d;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		ctrl = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					ctrl.load_item = 1'b1;
					state_d = ST_DECODE;
				end
			end
			ST_DECODE: begin
				unique case (stat.cmd)
					xrs_pkg::CMD_RESEED: begin
						ctrl.reseed = 1'b1;
						state_d = ST_FINISH;
					end
					xrs_pkg::CMD_RAW, xrs_pkg::CMD_TOP: state_d = ST_DRAW;
					xrs_pkg::CMD_BOUNDED: state_d = stat.bound_zero ? ST_FINISH : ST_DRAW;
					xrs_pkg::CMD_SKIP: state_d = ST_SKIP;
					default: state_d = ST_FINISH;
				endcase
			end
			ST_SKIP: begin
				if (stat.count_le1) begin
					state_d = ST_DRAW;
				end else begin
					ctrl.skip_step = 1'b1;
				end
			end
			ST_DRAW: begin
				ctrl.draw = 1'b1;
				state_d = (stat.cmd == xrs_pkg::CMD_BOUNDED) ? ST_MUL : ST_FINISH;
			end
			ST_MUL: begin
				ctrl.mul = 1'b1;
				state_d = ST_CHECK;
			end
			ST_CHECK: begin
				if (stat.low_ge_bound) begin
					state_d = ST_FINISH;
				end else if (!stat.thr_done) begin
					ctrl.div_start = 1'b1;
					state_d = ST_DIV;
				end else if (stat.low_lt_thr) begin
					state_d = ST_DRAW;
				end else begin
					state_d = ST_FINISH;
				end
			end
			ST_DIV: begin
				ctrl.div_step = 1'b1;
				if (stat.div_last) begin
					state_d = ST_CHECK;
				end
			end
			ST_FINISH: begin
				if (stat.out_free) begin
					ctrl.out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

@@ hdl/xrs_dp.sv @@
// Datapath: generator state, seed registers, multiplier, threshold divider and result register.
module xrs_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [xrs_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [xrs_pkg::WORD_W-1:0]          cfg_data,
	xrs_cmd_if.sink                             cmd,
	xrs_res_if.source                           res,
	input  xrs_pkg::dp_ctrl_t                   ctrl,
	output xrs_pkg::dp_stat_t                   stat
);

	localparam int unsigned W = xrs_pkg::WORD_W;
	localparam int unsigned BW = xrs_pkg::BOUND_W;

	logic [W-1:0] seed_hi_q, seed_lo_q;
	logic [W-1:0] st_lo_q, st_hi_q;

	xrs_pkg::cmd_t                cmd_q;
	logic [BW-1:0]                bound_q;
	logic [xrs_pkg::BITS_W-1:0]   bits_q;
	logic [xrs_pkg::STEP_W-1:0]   count_q;

	logic [W-1:0]                 draw_q;
	logic [W-1:0]                 prod_q;

	logic [BW-1:0]                rem_q;
	logic [31:0]                  dvd_q;
	logic [xrs_pkg::DIV_CNT_W-1:0] div_cnt_q;
	logic                         thr_done_q;

	logic                         out_valid_q;
	logic [W-1:0]                 value_q;
	logic                         error_q;

	logic [W-1:0]                 result;
	logic                         result_err;
	logic [W-1:0]                 top_bits;
	logic [31:0]                  div_trial;
	logic [31:0]                  div_diff;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_hi_q <= '0;
			seed_lo_q <= '0;
		end else if (cfg_we) begin
			unique case (xrs_pkg::reg_idx_t'(cfg_index))
				xrs_pkg::REG_SEED_HIGH: seed_hi_q <= cfg_data;
				xrs_pkg::REG_SEED_LOW:  seed_lo_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Generator state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_lo_q <= xrs_pkg::ZERO_SEED_LOW;
			st_hi_q <= xrs_pkg::ZERO_SEED_HIGH;
		end else if (ctrl.reseed) begin
			if ((seed_hi_q | seed_lo_q) == '0) begin
				st_lo_q <= xrs_pkg::ZERO_SEED_LOW;
				st_hi_q <= xrs_pkg::ZERO_SEED_HIGH;
			end else begin
				st_lo_q <= seed_lo_q;
				st_hi_q <= seed_hi_q;
			end
		end else if (ctrl.draw || ctrl.skip_step) begin
			st_lo_q <= xrs_pkg::next_lo(st_lo_q, st_hi_q);
			st_hi_q <= xrs_pkg::next_hi(st_lo_q, st_hi_q);
		end
	end

	// Item capture, draw, product and skip counter.
	always_ff @(posedge clk) begin
		if (ctrl.load_item) begin
			cmd_q   <= xrs_pkg::cmd_t'(cmd.command);
			bound_q <= cmd.bound;
			bits_q  <= cmd.bit_count;
			count_q <= cmd.step_count;
		end else if (ctrl.skip_step) begin
			count_q <= count_q - 1'b1;
		end
		if (ctrl.draw) begin
			draw_q <= xrs_pkg::draw_out(st_lo_q, st_hi_q);
		end
		if (ctrl.mul) begin
			prod_q <= W'(draw_q[31:0] * {1'b0, bound_q});
		end
	end

	// Threshold divider: (2^32 - bound) mod bound, one quotient bit per cycle.
	assign div_trial = {rem_q, dvd_q[31]};
	assign div_diff  = div_trial - {1'b0, bound_q};

	always_ff @(posedge clk) begin
		if (ctrl.div_start) begin
			rem_q     <= '0;
			dvd_q     <= 32'd0 - {1'b0, bound_q};
			div_cnt_q <= '0;
		end else if (ctrl.div_step) begin
			rem_q     <= (div_trial >= {1'b0, bound_q}) ? div_diff[BW-1:0] : div_trial[BW-1:0];
			dvd_q     <= {dvd_q[30:0], 1'b0};
			div_cnt_q <= div_cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_done_q <= 1'b0;
		end else if (ctrl.load_item) begin
			thr_done_q <= 1'b0;
		end else if (ctrl.div_step && stat.div_last) begin
			thr_done_q <= 1'b1;
		end
	end

	// Status.
	always_comb begin
		stat.cmd          = cmd_q;
		stat.bound_zero   = (bound_q == '0);
		stat.count_le1    = (count_q <= 32'd1);
		stat.low_ge_bound = (prod_q[31:0] >= {1'b0, bound_q});
		stat.thr_done     = thr_done_q;
		stat.low_lt_thr   = (prod_q[31:0] < {1'b0, rem_q});
		stat.div_last     = (div_cnt_q == '1);
		stat.out_free     = !out_valid_q || res.ready;
	end

	// Result selection.
	always_comb begin
		if (bits_q == '0) begin
			top_bits = '0;
		end else if (bits_q >= 7'd64) begin
			top_bits = draw_q;
		end else begin
			top_bits = draw_q >> (7'd64 - bits_q);
		end
	end

	always_comb begin
		result = '0;
		result_err = 1'b0;
		case (cmd_q)
			xrs_pkg::CMD_RAW, xrs_pkg::CMD_SKIP: result = draw_q;
			xrs_pkg::CMD_TOP: result = top_bits;
			xrs_pkg::CMD_BOUNDED: begin
				if (bound_q == '0) begin
					result_err = 1'b1;
				end else begin
					result = {32'd0, prod_q[W-1:32]};
				end
			end
			default: ;
		endcase
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.out_load) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.out_load) begin
			value_q <= result;
			error_q <= result_err;
		end
	end

	assign res.valid = out_valid_q;
	assign res.value = value_q;
	assign res.error = error_q;

endmodule

@@ hdl/xoroshiro128pp_random_source_unit.sv @@
// Top level of the xoroshiro128++ random source: controller and datapath.
//
// This block keeps a 128-bit xoroshiro128++ state and serves one command per item:
// reseed from the two seed registers (an all-zero seed loads fixed constants), a raw
// 64-bit draw, a bounded integer in [0, bound) by multiply-high with rejection, the
// top bit_count bits of a draw, and a skip that returns the last of step_count draws.
// Items are handled one at a time by a controller state machine. A reseed passes
// through the decode and finish states to the result register, a raw draw or a
// top-bits request through the decode, draw and finish states. A bounded integer
// adds the multiply and check states for the registered 32 by 31 bit multiply;
// when the first product falls in the rejection band the threshold is formed by a
// one-bit-per-cycle divider, and each further rejected draw passes again through
// the draw, multiply and check states. A skip advances the state by one step per
// cycle. The result register lets a new item be accepted while the previous result
// still waits to be taken. Configuration is to be written through cfg_we, cfg_index
// and cfg_data only while the block is idle; the block itself does not enforce it.
module xoroshiro128pp_random_source_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [xrs_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [xrs_pkg::WORD_W-1:0]      cfg_data,
	xrs_cmd_if.sink                         cmd,
	xrs_res_if.source                       res
);

	xrs_pkg::dp_ctrl_t ctrl;
	xrs_pkg::dp_stat_t stat;

	// The controller owns the input handshake; the datapath owns the result register.
	xrs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (cmd.valid),
		.in_ready (cmd.ready),
		.stat     (stat),
		.ctrl     (ctrl)
	);

	xrs_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.res       (res),
		.ctrl      (ctrl),
		.stat      (stat)
	);

endmodule
